### rtl/core/ecm_pkg.sv
`default_nettype none
package ecm_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int ROUTE_REGS   = 4;

    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 2;
    localparam int OCHAN_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int Q24_W      = 26;
    localparam int ROUTE_W    = 22;

    // serial datapath: one multiplier bit or one quotient bit per cycle
    localparam int STEPS = 26;
    localparam int CNT_W = 5;

    typedef logic [Q24_W-1:0]   t_q24;
    typedef logic [ROUTE_W-1:0] t_route;

    localparam t_q24 ONE_Q24     = 26'd16777216;
    localparam t_q24 ENV_MIN_Q24 = 26'd8388608;
    localparam t_q24 ENV_MAX_Q24 = 26'd33554432;
    // 2^48 / 2^26: partial remainder ahead of the first quotient bit
    localparam t_q24 DIV_INIT    = 26'd4194304;

    localparam logic [OCHAN_W-1:0] NO_TARGET   = 6'd63;
    localparam t_route             ROUTE_RESET = 22'd4128768;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE3  = 3'd6;

endpackage
`default_nettype wire

### rtl/core/ecm_in_if.sv
`default_nettype none
interface ecm_in_if;
    import ecm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;

    modport source (output valid, output sample, output channel, input ready);
    modport sink   (input valid, input sample, input channel, output ready);
endinterface
`default_nettype wire

### rtl/core/ecm_out_if.sv
`default_nettype none
interface ecm_out_if;
    import ecm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OCHAN_W-1:0]         out_channel;
    logic signed [SAMPLE_W-1:0] contribution;
    logic                       active;

    modport source (output valid, output out_channel, output contribution,
                    output active, input ready);
    modport sink   (input valid, input out_channel, input contribution,
                    input active, output ready);
endinterface
`default_nettype wire

### rtl/core/envelope_compressor_mixer_core.sv
`default_nettype none
// Channel  Direction  Payload                                 Transaction
// i_in     sink       sample[15:0] s, channel[1:0]            valid & ready
// o_out    source     out_channel[5:0], contribution[15:0] s, valid & ready
//                     active
// i_cfg    write      i_cfg_idx[2:0], i_cfg_data[25:0]        i_cfg_we
//
// Channel-0 transaction: accept, envelope multiply, reciprocal divide, gain
// multiply, output; the envelope multiply is skipped when the envelope
// already sits at its target. Other channels: accept, gain multiply, output.
// One shared shift-add unit and one restoring divider, each one bit per
// cycle. Reset: synchronous, active low, envelope and gain at 1.0. The
// output register holds a result while o_out stalls; the next transaction
// is taken meanwhile and waits only at its own output.
module envelope_compressor_mixer_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [ecm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [ecm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ecm_in_if.sink                           i_in,
    ecm_out_if.source                        o_out
);
    import ecm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENV  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PROD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic                  r_enable;
    t_q24                  r_attack;
    logic [Q24_W-2:0]      r_release;
    t_route                r_route [ROUTE_REGS];

    t_q24                  r_env;
    t_q24                  r_gain;

    logic [2:0]            r_state;
    logic [CNT_W-1:0]      r_cnt;
    t_q24                  r_amp;
    logic                  r_up;
    logic [30:0]           r_pmag;
    logic                  r_neg;
    logic                  r_inactive;
    logic [OCHAN_W-1:0]    r_target;

    logic [30:0]           r_mcand;
    logic [30:0]           r_acc_hi;
    logic [Q24_W-1:0]      r_acc_lo;
    t_q24                  r_rem;
    t_q24                  r_quo;

    logic                       r_ovalid;
    logic [OCHAN_W-1:0]         r_ochan;
    logic signed [SAMPLE_W-1:0] r_ocontrib;
    logic                       r_oactive;

    // accept-time decode
    logic                  w_accept;
    logic [16:0]           w_smag;
    t_route                w_route;
    logic [15:0]           w_g;
    logic [16:0]           w_gmag;
    logic [33:0]           w_pprod;
    logic [26:0]           w_amp27;
    t_q24                  w_amp;
    t_q24                  w_am;
    t_q24                  w_rm;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_smag   = i_in.sample[15] ? (17'd0 - {i_in.sample[15], i_in.sample})
                                      : {1'b0, i_in.sample};
    assign w_route  = r_route[i_in.channel];
    assign w_g      = w_route[15:0];
    assign w_gmag   = w_g[15] ? (17'd0 - {w_g[15], w_g}) : {1'b0, w_g};
    assign w_pprod  = w_smag * w_gmag;
    assign w_amp27  = {w_smag, 10'b0};
    assign w_am     = (r_attack < ONE_Q24) ? ONE_Q24 : r_attack;
    assign w_rm     = ({1'b0, r_release} > ONE_Q24) ? ONE_Q24 : {1'b0, r_release};

    always_comb begin
        if (!r_enable) begin
            w_amp = ONE_Q24;
        end else if (w_amp27 < {1'b0, ENV_MIN_Q24}) begin
            w_amp = ENV_MIN_Q24;
        end else if (w_amp27 > {1'b0, ENV_MAX_Q24}) begin
            w_amp = ENV_MAX_Q24;
        end else begin
            w_amp = w_amp27[25:0];
        end
    end

    // shift-add step
    logic [31:0]           w_sum;
    logic [30:0]           n_acc_hi;
    logic [Q24_W-1:0]      n_acc_lo;
    logic [27:0]           w_nxt;
    t_q24                  w_env_new;

    assign w_sum    = {1'b0, r_acc_hi} + (r_acc_lo[0] ? {1'b0, r_mcand} : 32'd0);
    assign n_acc_hi = w_sum[31:1];
    assign n_acc_lo = {w_sum[0], r_acc_lo[25:1]};
    assign w_nxt    = {n_acc_hi[25:0], n_acc_lo[25:24]};

    always_comb begin
        if (r_up) begin
            w_env_new = (w_nxt < {2'b0, r_amp}) ? w_nxt[25:0] : r_amp;
        end else begin
            w_env_new = (w_nxt > {2'b0, r_amp}) ? w_nxt[25:0] : r_amp;
        end
    end

    // restoring divide step, dividend bits below the top are zero
    logic [26:0]           w_trial;
    logic                  w_ge;
    t_q24                  n_rem;
    t_q24                  n_quo;

    assign w_trial = {r_rem, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_env};
    assign n_rem   = w_ge ? 26'(w_trial - {1'b0, r_env}) : w_trial[25:0];
    assign n_quo   = {r_quo[24:0], w_ge};

    // round half away from zero, saturate
    logic [20:0]           w_rnd;
    logic [19:0]           w_r;
    logic signed [SAMPLE_W-1:0] w_contrib;

    assign w_rnd = {1'b0, r_acc_hi[30:11]} + 21'd1;
    assign w_r   = w_rnd[20:1];

    always_comb begin
        if (r_neg) begin
            w_contrib = (w_r > 20'd32768) ? -16'sd32768 : SAMPLE_W'(20'd0 - w_r);
        end else begin
            w_contrib = (w_r > 20'd32767) ? 16'sd32767 : w_r[15:0];
        end
    end

    logic                  w_load;

    assign w_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.out_channel  = r_ochan;
    assign o_out.contribution = r_ocontrib;
    assign o_out.active       = r_oactive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_attack  <= ONE_Q24;
            r_release <= ONE_Q24[24:0];
            for (int k = 0; k < ROUTE_REGS; k++) begin
                r_route[k] <= ROUTE_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:  r_enable   <= i_cfg_data[0];
                REG_ATTACK:  r_attack   <= i_cfg_data[25:0];
                REG_RELEASE: r_release  <= i_cfg_data[24:0];
                REG_ROUTE0:  r_route[0] <= i_cfg_data[21:0];
                REG_ROUTE1:  r_route[1] <= i_cfg_data[21:0];
                REG_ROUTE2:  r_route[2] <= i_cfg_data[21:0];
                REG_ROUTE3:  r_route[3] <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_env    <= ONE_Q24;
            r_gain   <= ONE_Q24;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pmag     <= w_pprod[30:0];
                        r_neg      <= i_in.sample[15] ^ w_g[15];
                        r_target   <= w_route[21:16];
                        r_inactive <= (w_route[21:16] == NO_TARGET) || (w_g == 16'd0)
                                      || (32'(i_in.channel) >= NUM_CHANNELS);
                        r_amp      <= w_amp;
                        r_up       <= w_amp > r_env;
                        r_cnt      <= '0;
                        r_acc_hi   <= '0;
                        if (i_in.channel == '0) begin
                            r_mcand  <= {5'b0, r_env};
                            r_acc_lo <= (w_amp > r_env) ? w_am : w_rm;
                            if (w_amp == r_env) begin
                                r_rem   <= DIV_INIT;
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_ENV;
                            end
                        end else begin
                            r_mcand  <= w_pprod[30:0];
                            r_acc_lo <= r_gain;
                            r_state  <= S_PROD;
                        end
                    end
                end
                S_ENV: begin
                    r_acc_hi <= n_acc_hi;
                    r_acc_lo <= n_acc_lo;
                    if (r_cnt == LAST_STEP) begin
                        r_env   <= w_env_new;
                        r_rem   <= DIV_INIT;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_cnt == LAST_STEP) begin
                        r_gain   <= n_quo;
                        r_mcand  <= r_pmag;
                        r_acc_hi <= '0;
                        r_acc_lo <= n_quo;
                        r_cnt    <= '0;
                        r_state  <= S_PROD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_PROD: begin
                    r_acc_hi <= n_acc_hi;
                    r_acc_lo <= n_acc_lo;
                    if (r_cnt == LAST_STEP) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_ochan    <= r_inactive ? '0 : r_target;
                        r_ocontrib <= r_inactive ? '0 : w_contrib;
                        r_oactive  <= !r_inactive;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_env >= ENV_MIN_Q24) && (r_env <= ENV_MAX_Q24))
        else $error("envelope out of range");

    a_ch0_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.channel == '0)) |=> (r_state == S_ENV || r_state == S_DIV))
        else $error("channel 0 skipped envelope update");

    a_other_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.channel != '0)) |=> (r_state == S_PROD))
        else $error("envelope touched by non-zero channel");

    a_prod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROD && r_cnt == LAST_STEP) |=> (r_state == S_OUT))
        else $error("product did not finish");

    a_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_oactive) |-> (r_ocontrib == '0 && r_ochan == '0))
        else $error("inactive result not cleared");

endmodule
`default_nettype wire

### test/ecm_mix_monitor.sv
`timescale 1ns / 100ps
module ecm_mix_monitor (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [ecm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [ecm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ecm_in_if                               i_in,
    ecm_out_if                              i_out,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_samples,
    output int                              o_routed,
    output int                              o_full_scale
);
    import ecm_pkg::*;

    typedef struct packed {
        logic [OCHAN_W-1:0]         out_channel;
        logic signed [SAMPLE_W-1:0] contribution;
        logic                       active;
    } t_mix_result;

    t_mix_result mix_queue[$];
    t_mix_result want;
    t_mix_result got;

    // local copy of the block state and registers
    logic        en;
    t_q24        attack_q24;
    logic [24:0] release_q25;
    t_route      routes[ROUTE_REGS];
    t_q24        env_q24;
    t_q24        gain_q24;

    function automatic void follow_envelope(input logic signed [SAMPLE_W-1:0] s);
        t_q24        amp;
        t_q24        rise;
        t_q24        fall;
        logic [63:0] step;
        int          mag;
        rise = (attack_q24 < ONE_Q24) ? ONE_Q24 : attack_q24;
        fall = ({1'b0, release_q25} > ONE_Q24) ? ONE_Q24 : {1'b0, release_q25};
        if (en) begin
            mag = (s < 0) ? -int'(s) : int'(s);
            amp = Q24_W'(mag << 10);
            if (amp < ENV_MIN_Q24) amp = ENV_MIN_Q24;
            if (amp > ENV_MAX_Q24) amp = ENV_MAX_Q24;
        end else begin
            amp = ONE_Q24;
        end
        if (amp > env_q24) begin
            step = (64'(env_q24) * 64'(rise)) >> 24;
            env_q24 = (step < 64'(amp)) ? Q24_W'(step) : amp;
        end else if (amp < env_q24) begin
            step = (64'(env_q24) * 64'(fall)) >> 24;
            env_q24 = (step > 64'(amp)) ? Q24_W'(step) : amp;
        end
        if (env_q24 == '0) env_q24 = ENV_MIN_Q24;
        gain_q24 = Q24_W'((64'd1 << 48) / 64'(env_q24));
    endfunction

    function automatic t_mix_result mix_sample(input logic signed [SAMPLE_W-1:0] s,
                                               input logic [CHAN_W-1:0] ch);
        t_mix_result        r;
        t_route             route;
        logic signed [15:0] g;
        longint             prod;
        logic [63:0]        prod_mag;
        logic [63:0]        scaled;
        logic [63:0]        rnd;
        r = '0;
        if (int'(ch) >= NUM_CHANNELS) return r;
        route = routes[ch];
        g = route[15:0];
        if (route[21:16] == NO_TARGET || g == 0) return r;
        prod = longint'(s) * longint'(g);
        prod_mag = (prod < 0) ? -prod : prod;
        scaled = prod_mag * 64'(gain_q24);
        rnd = (scaled + (64'd1 << 37)) >> 38;
        if (prod < 0) begin
            r.contribution = (rnd > 64'd32768) ? 16'sh8000 : 16'(-longint'(rnd));
        end else begin
            r.contribution = (rnd > 64'd32767) ? 16'sh7fff : rnd[15:0];
        end
        r.out_channel = route[21:16];
        r.active = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            en = 1'b1;
            attack_q24 = ONE_Q24;
            release_q25 = ONE_Q24[24:0];
            for (int k = 0; k < ROUTE_REGS; k++) routes[k] = ROUTE_RESET;
            env_q24 = ONE_Q24;
            gain_q24 = ONE_Q24;
            mix_queue.delete();
            o_mismatches = 0;
            o_samples = 0;
            o_routed = 0;
            o_full_scale = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ENABLE:  en = i_cfg_data[0];
                    REG_ATTACK:  attack_q24 = i_cfg_data[Q24_W-1:0];
                    REG_RELEASE: release_q25 = i_cfg_data[24:0];
                    REG_ROUTE0, REG_ROUTE1, REG_ROUTE2, REG_ROUTE3: begin
                        routes[CHAN_W'(i_cfg_idx - REG_ROUTE0)] = i_cfg_data[ROUTE_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.channel == '0) follow_envelope(i_in.sample);
                want = mix_sample(i_in.sample, i_in.channel);
                mix_queue.push_back(want);
                o_samples++;
                if (want.active) begin
                    o_routed++;
                    if (want.contribution == 16'sh7fff || want.contribution == 16'sh8000)
                        o_full_scale++;
                end
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.out_channel, i_out.contribution, i_out.active};
                if (mix_queue.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: unexpected transaction: ch %0d val %0d act %0d",
                                 $time, got.out_channel, got.contribution, got.active);
                end else begin
                    want = mix_queue.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display({"%0t: expected ch %0d val %0d act %0d, ",
                                      "got ch %0d val %0d act %0d"}, $time,
                                     want.out_channel, want.contribution, want.active,
                                     got.out_channel, got.contribution, got.active);
                    end
                end
            end
        end
        o_pending = mix_queue.size();
    end

endmodule

### test/tb_envelope_compressor_mixer_core.sv
`timescale 1ns / 100ps
module tb_envelope_compressor_mixer_core;
    import ecm_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ecm_in_if  in_ch();
    ecm_out_if out_ch();

    int mismatches;
    int pending;
    int samples;
    int routed;
    int full_scale;
    int settings_used = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    envelope_compressor_mixer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    ecm_mix_monitor mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_samples    (samples),
        .o_routed     (routed),
        .o_full_scale (full_scale)
    );

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) cycles++;

    initial begin
        wait (cycles >= RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic t_route route_word(input logic [OCHAN_W-1:0] tgt,
                                          input logic [SAMPLE_W-1:0] g);
        return {tgt, g};
    endfunction

    function automatic t_route pick_route();
        logic [OCHAN_W-1:0]  tgt;
        logic [SAMPLE_W-1:0] g;
        tgt = ($urandom_range(7) == 0) ? NO_TARGET : OCHAN_W'($urandom_range(62));
        case ($urandom_range(7))
            0:       g = '0;
            1:       g = 16'h8000;
            2:       g = 16'h7fff;
            default: g = SAMPLE_W'($urandom);
        endcase
        return {tgt, g};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        v = 0;
        case ($urandom_range(3))
            0: v = int'($urandom);
            1: v = int'($urandom_range(16382)) - 8191;
            2: begin
                case ($urandom_range(5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = 1;
                    4: v = -1;
                    default: v = 8192;
                endcase
            end
            default: begin
                v = int'($urandom_range(32767, 16384));
                if ($urandom_range(1) == 0) v = -v;
            end
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int ch);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.channel <= CHAN_W'(ch);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic en, input t_q24 att, input logic [24:0] rel,
                                 input t_route r0, input t_route r1,
                                 input t_route r2, input t_route r3);
        drain();
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_ATTACK, CFG_DATA_W'(att));
        write_reg(REG_RELEASE, CFG_DATA_W'(rel));
        write_reg(REG_ROUTE0, CFG_DATA_W'(r0));
        write_reg(REG_ROUTE1, CFG_DATA_W'(r1));
        write_reg(REG_ROUTE2, CFG_DATA_W'(r2));
        write_reg(REG_ROUTE3, CFG_DATA_W'(r3));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int          count;
        bit          paused;
        logic        en;
        t_q24        att;
        logic [24:0] rel;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.sample  <= '0;
        in_ch.channel <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings leave every channel unrouted
        send_sample(16'sd12000, 0);
        send_sample(-16'sd5, 2);

        load_settings(1'b1, 26'd33554432, 25'd8388608,
                      route_word(6'd0, 16'd16384), route_word(6'd62, 16'h8000),
                      route_word(6'd5, 16'h7fff), route_word(NO_TARGET, 16'd100));
        send_sample(16'sd32767, 0);
        send_sample(-16'sd32768, 0);
        send_sample(-16'sd32768, 1);
        send_sample(16'sd32767, 2);
        send_sample(16'sd1, 3);
        send_sample(16'sd0, 0);
        send_sample(-16'sd1, 0);
        send_sample(16'sd16384, 1);
        send_sample(-16'sd32768, 2);
        send_sample(16'sd8192, 0);
        send_sample(16'sd1, 1);

        // attack below unity and release above unity saturate to 1.0
        load_settings(1'b0, '0, 25'h1ffffff,
                      route_word(6'd0, 16'd1), route_word(6'd33, 16'hc000),
                      route_word(6'd12, 16'd4096), route_word(6'd7, 16'd0));
        send_sample(16'sd32767, 0);
        send_sample(-16'sd32768, 0);
        send_sample(16'sd5, 3);
        send_sample(-16'sd7, 1);
        send_sample(16'sd100, 2);

        load_settings(1'b0, 26'h3ffffff, '0,
                      route_word(6'd1, 16'h7fff), route_word(6'd2, 16'h8000),
                      route_word(6'd3, 16'd16384), route_word(6'd4, 16'hffff));
        send_sample(16'sd0, 0);
        send_sample(16'sd123, 0);
        send_sample(-16'sd4000, 1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    att = 26'h3ffffff;
                    rel = '0;
                end
                1: begin
                    att = ONE_Q24;
                    rel = ONE_Q24[24:0];
                end
                2: begin
                    att = Q24_W'($urandom_range(ONE_Q24 - 1));
                    rel = 25'($urandom_range(32'h1ffffff, ONE_Q24 + 1));
                end
                default: begin
                    att = Q24_W'($urandom_range(ONE_Q24 + (ONE_Q24 >> 2), ONE_Q24));
                    rel = 25'($urandom_range(ONE_Q24, ONE_Q24 - (ONE_Q24 >> 2)));
                end
            endcase
            en = (ph % 3 != 2);
            load_settings(en, att, rel, pick_route(), pick_route(), pick_route(),
                          pick_route());

            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_requests++;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct = 23;
                    recv_stall_pct = 23;
                end
            endcase

            count = 0;
            paused = 1'b0;
            while (count < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    send_sample(pick_sample(), int'($urandom_range(NUM_CHANNELS - 1)));
                    count++;
                end else begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        send_sample(pick_sample(), c);
                        count++;
                    end
                end
                if (!paused && count >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d samples, %0d routed (%0d at full scale), %0d register settings.",
                 samples, routed, full_scale, settings_used);
        $display("Idling: none, sender, receiver, both; %0d long receiver hold-offs.",
                 hold_requests);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/ecm_pkg.sv
rtl/core/ecm_in_if.sv
rtl/core/ecm_out_if.sv
rtl/core/envelope_compressor_mixer_core.sv
test/ecm_mix_monitor.sv
test/tb_envelope_compressor_mixer_core.sv
